// ===== hw/rtl/ppbb_pkg.sv =====
// Package with shared types and constants for the ping-pong byte buffer.
`timescale 1ns / 1ps

package ppbb_pkg;

    localparam int SIZE_W  = 13;
    localparam int DATA_W  = 8;
    localparam int TOTAL_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // Everything the control stage hands down the output pipeline.
    typedef struct packed {
        logic               status;
        logic               rd_ok;
        logic [TOTAL_W-1:0] total_written;
        logic [TOTAL_W-1:0] total_read;
    } ppbb_result_t;

endpackage

// ===== hw/rtl/ppbb_mem.sv =====
// Byte store for both buffers: one port, synchronous write, registered read.
`timescale 1ns / 1ps

module ppbb_mem #(
    parameter int AW = 12
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic                       re,
    input  logic [AW:0]                addr,
    input  logic [ppbb_pkg::DATA_W-1:0] wdata,
    output logic [ppbb_pkg::DATA_W-1:0] rdata
);

    localparam int DEPTH = 2 << AW;

    logic [ppbb_pkg::DATA_W-1:0] mem [DEPTH];
    logic [ppbb_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ppbb_ctrl.sv =====
// Fill and consume counters, buffer selectors, totals and memory access control.
`timescale 1ns / 1ps

module ppbb_ctrl #(
    parameter int BUF_DEPTH = 4096,
    parameter int AW        = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ppbb_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                        accept,
    input  logic                        op,
    input  logic                        last_of_call,
    output logic                        mem_we,
    output logic                        mem_re,
    output logic [AW:0]                 mem_addr,
    output ppbb_pkg::ppbb_result_t      result
);

    localparam int CW = $clog2(BUF_DEPTH + 1);

    logic [ppbb_pkg::SIZE_W-1:0]  size_reg;
    logic [CW-1:0]                fc0_reg, fc1_reg, cc0_reg, cc1_reg;
    logic [CW-1:0]                fc0_next, fc1_next, cc0_next, cc1_next;
    logic                         fsel_reg, rsel_reg, fsel_next, rsel_next;
    logic [ppbb_pkg::TOTAL_W-1:0] wtot_reg, rtot_reg, wtot_next, rtot_next;

    logic [31:0]   size_wide;
    logic [CW-1:0] size_eff;
    logic [CW-1:0] fc_f, fc_r, cc_r, fc_inc, cc_inc, fc_r_after;
    logic          wr_ok, rd_ok, shared;

    assign size_wide = (32'(size_reg) > 32'(BUF_DEPTH)) ? 32'(BUF_DEPTH) : 32'(size_reg);
    assign size_eff  = size_wide[CW-1:0];

    assign shared = (fsel_reg == rsel_reg);
    assign fc_f   = fsel_reg ? fc1_reg : fc0_reg;
    assign fc_r   = rsel_reg ? fc1_reg : fc0_reg;
    assign cc_r   = rsel_reg ? cc1_reg : cc0_reg;
    assign fc_inc = fc_f + CW'(1);
    assign cc_inc = cc_r + CW'(1);
    assign wr_ok  = (fc_f < size_eff);
    assign rd_ok  = (cc_r < fc_r);
    // A switch happens only when filling and reading share a buffer, so the
    // read buffer's fill count after this write is the incremented one.
    assign fc_r_after = fc_inc;

    always_comb begin
        fc0_next  = fc0_reg;
        fc1_next  = fc1_reg;
        cc0_next  = cc0_reg;
        cc1_next  = cc1_reg;
        fsel_next = fsel_reg;
        rsel_next = rsel_reg;
        wtot_next = wtot_reg;
        rtot_next = rtot_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = {fsel_reg, fc_f[AW-1:0]};
        if (accept && op == ppbb_pkg::OP_WRITE && wr_ok) begin
            mem_we    = 1'b1;
            wtot_next = wtot_reg + 32'd1;
            if (fsel_reg) begin
                fc1_next = fc_inc;
            end else begin
                fc0_next = fc_inc;
            end
            if ((fc_inc >= size_eff || last_of_call) && shared) begin
                if (fsel_reg) begin
                    fc0_next = '0;
                    cc0_next = '0;
                end else begin
                    fc1_next = '0;
                    cc1_next = '0;
                end
                if (cc_r == fc_r_after) begin
                    rsel_next = ~rsel_reg;
                end
                fsel_next = ~fsel_reg;
            end
        end else if (accept && op == ppbb_pkg::OP_READ && rd_ok) begin
            mem_re    = 1'b1;
            mem_addr  = {rsel_reg, cc_r[AW-1:0]};
            rtot_next = rtot_reg + 32'd1;
            if (cc_inc >= fc_r) begin
                if (shared) begin
                    if (rsel_reg) begin
                        fc1_next = '0;
                        cc1_next = '0;
                    end else begin
                        fc0_next = '0;
                        cc0_next = '0;
                    end
                end else begin
                    rsel_next = ~rsel_reg;
                    if (rsel_reg) begin
                        cc1_next = cc_inc;
                    end else begin
                        cc0_next = cc_inc;
                    end
                end
            end else if (rsel_reg) begin
                cc1_next = cc_inc;
            end else begin
                cc0_next = cc_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= ppbb_pkg::SIZE_RESET;
            fc0_reg  <= '0;
            fc1_reg  <= '0;
            cc0_reg  <= '0;
            cc1_reg  <= '0;
            fsel_reg <= 1'b0;
            rsel_reg <= 1'b0;
            wtot_reg <= '0;
            rtot_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            fc0_reg  <= fc0_next;
            fc1_reg  <= fc1_next;
            cc0_reg  <= cc0_next;
            cc1_reg  <= cc1_next;
            fsel_reg <= fsel_next;
            rsel_reg <= rsel_next;
            wtot_reg <= wtot_next;
            rtot_reg <= rtot_next;
        end
    end

    always_comb begin
        result.rd_ok         = mem_re;
        result.status        = (mem_we || mem_re) ? ppbb_pkg::STATUS_OK
                                                  : ppbb_pkg::STATUS_REFUSED;
        result.total_written = wtot_next;
        result.total_read    = rtot_next;
    end

endmodule

// ===== hw/rtl/ppbb_out.sv =====
// Memory-latency stage and output register of the result channel.
`timescale 1ns / 1ps

module ppbb_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_accept,
    input  ppbb_pkg::ppbb_result_t       in_result,
    input  logic [ppbb_pkg::DATA_W-1:0]  mem_rdata,
    output logic                         s_ready,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_status,
    output logic [ppbb_pkg::DATA_W-1:0]  m_read_data,
    output logic [ppbb_pkg::TOTAL_W-1:0] m_total_written,
    output logic [ppbb_pkg::TOTAL_W-1:0] m_total_read
);

    logic                         p1_valid_reg, p1_valid_next;
    ppbb_pkg::ppbb_result_t       p1_res_reg;
    logic                         m_valid_reg, m_valid_next;
    logic                         m_status_reg;
    logic [ppbb_pkg::DATA_W-1:0]  m_data_reg;
    logic [ppbb_pkg::TOTAL_W-1:0] m_wtot_reg, m_rtot_reg;
    logic                         advance;

    // The memory data register only changes on a new read, and a new
    // transaction is taken only when the held one moves on this edge.
    assign advance = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || !m_valid_reg || m_ready;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (in_accept) begin
            p1_valid_next = 1'b1;
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p1_res_reg <= in_result;
        end
        if (advance) begin
            m_status_reg <= p1_res_reg.status;
            m_data_reg   <= p1_res_reg.rd_ok ? mem_rdata : '0;
            m_wtot_reg   <= p1_res_reg.total_written;
            m_rtot_reg   <= p1_res_reg.total_read;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_read_data     = m_data_reg;
    assign m_total_written = m_wtot_reg;
    assign m_total_read    = m_rtot_reg;

endmodule

// ===== hw/rtl/ping_pong_byte_buffer_unit.sv =====
// Path: an accepted transaction waits beside the byte-store read register, then in an output register.
// Throughput: one transaction per cycle unless m_ready holds results back.
// Each transaction uses the single byte-store port at most once; refused ones leave it idle.
// Reset (aresetn low, synchronous) clears counters, selectors, totals and valid flags.
// The byte store is not cleared; buffer_size returns to 4096.
`timescale 1ns / 1ps

module ping_pong_byte_buffer_unit #(
    parameter int BUF_DEPTH = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ppbb_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [ppbb_pkg::DATA_W-1:0]  s_write_data,
    input  logic                         s_last_of_call,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_status,
    output logic [ppbb_pkg::DATA_W-1:0]  m_read_data,
    output logic [ppbb_pkg::TOTAL_W-1:0] m_total_written,
    output logic [ppbb_pkg::TOTAL_W-1:0] m_total_read
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic                        accept;
    logic                        mem_we, mem_re;
    logic [AW:0]                 mem_addr;
    logic [ppbb_pkg::DATA_W-1:0] mem_rdata;
    ppbb_pkg::ppbb_result_t      result;

    assign accept = s_valid && s_ready;

    ppbb_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .op           (s_op),
        .last_of_call (s_last_of_call),
        .mem_we       (mem_we),
        .mem_re       (mem_re),
        .mem_addr     (mem_addr),
        .result       (result)
    );

    ppbb_mem #(
        .AW (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (s_write_data),
        .rdata (mem_rdata)
    );

    ppbb_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (accept),
        .in_result       (result),
        .mem_rdata       (mem_rdata),
        .s_ready         (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_read_data     (m_read_data),
        .m_total_written (m_total_written),
        .m_total_read    (m_total_read)
    );

    // A refused transaction or a write never carries a data byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ppbb_pkg::STATUS_REFUSED |-> m_read_data == '0)
        else $error("refused transaction carries nonzero read data");

    // The store is never written and read in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("byte store written and read in one cycle");

    // The store is only touched by an accepted transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we || mem_re) |-> accept)
        else $error("byte store accessed without a transaction");

    // Nothing is presented in the cycle after reset.
    assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

// ===== tb/sv/tb_ping_pong_byte_buffer_unit.sv =====
// Self-checking testbench for the ping-pong byte buffer unit.
`timescale 1ns / 1ps

module tb_ping_pong_byte_buffer_unit;

    localparam int BUF_DEPTH   = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct {
        logic                        op;
        logic [ppbb_pkg::DATA_W-1:0] data;
        logic                        last;
    } byte_op_t;

    typedef struct {
        logic                         status;
        logic [ppbb_pkg::DATA_W-1:0]  read_data;
        logic [ppbb_pkg::TOTAL_W-1:0] total_written;
        logic [ppbb_pkg::TOTAL_W-1:0] total_read;
    } byte_outcome_t;

    logic                         aclk;
    logic                         aresetn        = 1'b0;
    logic                         cfg_wr_en      = 1'b0;
    logic [ppbb_pkg::SIZE_W-1:0]  cfg_wr_data    = '0;
    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic                         s_op           = ppbb_pkg::OP_WRITE;
    logic [ppbb_pkg::DATA_W-1:0]  s_write_data   = '0;
    logic                         s_last_of_call = 1'b0;
    logic                         m_valid;
    logic                         m_ready        = 1'b0;
    logic                         m_status;
    logic [ppbb_pkg::DATA_W-1:0]  m_read_data;
    logic [ppbb_pkg::TOTAL_W-1:0] m_total_written;
    logic [ppbb_pkg::TOTAL_W-1:0] m_total_read;

    byte_op_t      byte_op_q[$];
    byte_outcome_t outcome_q[$];
    int            error_count    = 0;
    int            cycle_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    // Mirror of the buffer pair.
    logic [ppbb_pkg::DATA_W-1:0]  mirror_store [0:2*BUF_DEPTH-1];
    logic [ppbb_pkg::SIZE_W-1:0]  fill_cnt [2];
    logic [ppbb_pkg::SIZE_W-1:0]  consume_cnt [2];
    logic                         fill_sel;
    logic                         read_sel;
    logic [ppbb_pkg::TOTAL_W-1:0] written_sum;
    logic [ppbb_pkg::TOTAL_W-1:0] read_sum;
    logic [ppbb_pkg::SIZE_W-1:0]  size_reg;

    ping_pong_byte_buffer_unit #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_write_data   (s_write_data),
        .s_last_of_call (s_last_of_call),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_read_data    (m_read_data),
        .m_total_written(m_total_written),
        .m_total_read   (m_total_read)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic byte_outcome_t predict_byte_op(logic op,
                                                      logic [ppbb_pkg::DATA_W-1:0] data,
                                                      logic last);
        byte_outcome_t               res;
        logic [ppbb_pkg::SIZE_W-1:0] usable;
        logic [ppbb_pkg::SIZE_W-1:0] pos;
        logic                        f;
        logic                        r;
        res.status    = ppbb_pkg::STATUS_OK;
        res.read_data = '0;
        usable = (size_reg > BUF_DEPTH) ? ppbb_pkg::SIZE_W'(BUF_DEPTH) : size_reg;
        f = fill_sel;
        r = read_sel;
        if (op == ppbb_pkg::OP_WRITE) begin
            pos = fill_cnt[f];
            if (pos >= usable) begin
                res.status = ppbb_pkg::STATUS_REFUSED;
            end else begin
                mirror_store[int'(f) * BUF_DEPTH + int'(pos)] = data;
                fill_cnt[f] = pos + 1'b1;
                written_sum = written_sum + 1'b1;
                // The fill side may only move on if the reader is not using the other buffer.
                if ((fill_cnt[f] >= usable || (last && f == r)) && ~f != r) begin
                    consume_cnt[~f] = '0;
                    fill_cnt[~f] = '0;
                    if (consume_cnt[r] == fill_cnt[r]) begin
                        read_sel = ~r;
                    end
                    fill_sel = ~f;
                end
            end
        end else begin
            pos = consume_cnt[r];
            if (pos >= fill_cnt[r]) begin
                res.status = ppbb_pkg::STATUS_REFUSED;
            end else begin
                res.read_data = mirror_store[int'(r) * BUF_DEPTH + int'(pos)];
                consume_cnt[r] = pos + 1'b1;
                read_sum = read_sum + 1'b1;
                if (consume_cnt[r] >= fill_cnt[r]) begin
                    if (fill_sel == r) begin
                        consume_cnt[r] = '0;
                        fill_cnt[r] = '0;
                    end else begin
                        read_sel = ~r;
                    end
                end
            end
        end
        res.total_written = written_sum;
        res.total_read    = read_sum;
        return res;
    endfunction

    // Sender: the prediction is made when the transaction is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            byte_op_t nxt_op;
            if (s_valid) begin
                outcome_q.push_back(predict_byte_op(s_op, s_write_data, s_last_of_call));
            end
            if (byte_op_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt_op = byte_op_q.pop_front();
                s_valid        <= 1'b1;
                s_op           <= nxt_op.op;
                s_write_data   <= nxt_op.data;
                s_last_of_call <= nxt_op.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: compares every result transaction against the oldest prediction.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            byte_outcome_t want;
            if (outcome_q.size() == 0) begin
                $error("unexpected result transaction");
                error_count++;
            end else begin
                want = outcome_q.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    error_count++;
                end
                if (m_read_data !== want.read_data) begin
                    $error("read_data: expected %0d, got %0d", want.read_data, m_read_data);
                    error_count++;
                end
                if (m_total_written !== want.total_written) begin
                    $error("total_written: expected %0d, got %0d",
                           want.total_written, m_total_written);
                    error_count++;
                end
                if (m_total_read !== want.total_read) begin
                    $error("total_read: expected %0d, got %0d", want.total_read, m_total_read);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_ping_pong_byte_buffer_unit: errors");
            $finish;
        end
    end

    task automatic add_op(logic op, logic [ppbb_pkg::DATA_W-1:0] data, logic last);
        byte_op_t t;
        t.op   = op;
        t.data = data;
        t.last = last;
        byte_op_q.push_back(t);
    endtask

    // Checked at the falling edge so that all activity of the rising edge has settled.
    task automatic wait_drained();
        do @(negedge aclk);
        while (byte_op_q.size() != 0 || s_valid || outcome_q.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic set_buffer_size(logic [ppbb_pkg::SIZE_W-1:0] value);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        size_reg = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly write bursts followed by read bursts, with some loose transactions mixed in.
    task automatic add_traffic(int count, int sz);
        int added;
        int len;
        int rlen;
        int cap;
        added = 0;
        cap = (sz > BUF_DEPTH) ? BUF_DEPTH : sz;
        cap = 2 * cap + 2;
        if (cap > 40) begin
            cap = 40;
        end
        while (added < count) begin
            if ($urandom_range(0, 99) < 75) begin
                len = $urandom_range(1, cap);
                for (int i = 0; i < len; i++) begin
                    add_op(ppbb_pkg::OP_WRITE, ppbb_pkg::DATA_W'($urandom_range(0, 255)),
                           (i == len - 1) && ($urandom_range(0, 3) != 0));
                end
                rlen = $urandom_range(1, len + 2);
                for (int i = 0; i < rlen; i++) begin
                    add_op(ppbb_pkg::OP_READ, ppbb_pkg::DATA_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
                end
                added += len + rlen;
            end else begin
                add_op(1'($urandom_range(0, 1)), ppbb_pkg::DATA_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    initial begin
        int sizes [12] = '{1, 3, 2, 4096, 5, 0, 8, 1, 8191, 13, 2, 32};
        int send_pcts [4] = '{0, 65, 0, 8};
        int recv_pcts [4] = '{0, 0, 65, 8};

        fill_cnt[0]    = '0;
        fill_cnt[1]    = '0;
        consume_cnt[0] = '0;
        consume_cnt[1] = '0;
        fill_sel       = 1'b0;
        read_sel       = 1'b0;
        written_sum    = '0;
        read_sum       = '0;
        size_reg       = ppbb_pkg::SIZE_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset size: a call end on a shared buffer, draining it, then an empty read.
        add_op(ppbb_pkg::OP_WRITE, 8'h00, 1'b0);
        add_op(ppbb_pkg::OP_WRITE, 8'hFF, 1'b1);
        add_op(ppbb_pkg::OP_READ,  8'h00, 1'b0);
        add_op(ppbb_pkg::OP_READ,  8'h00, 1'b0);
        add_op(ppbb_pkg::OP_READ,  8'hFF, 1'b1);
        add_op(ppbb_pkg::OP_WRITE, 8'h80, 1'b0);
        add_op(ppbb_pkg::OP_WRITE, 8'h01, 1'b0);

        // Size zero refuses every write, even one that ends a call.
        set_buffer_size(ppbb_pkg::SIZE_W'(0));
        add_op(ppbb_pkg::OP_WRITE, 8'h5A, 1'b1);
        add_op(ppbb_pkg::OP_READ,  8'h00, 1'b0);
        add_op(ppbb_pkg::OP_WRITE, 8'h3C, 1'b0);

        // Largest register value behaves as the full depth.
        set_buffer_size(ppbb_pkg::SIZE_W'(8191));
        add_op(ppbb_pkg::OP_READ,  8'h00, 1'b0);
        add_op(ppbb_pkg::OP_WRITE, 8'hAA, 1'b0);
        add_op(ppbb_pkg::OP_WRITE, 8'h55, 1'b0);
        add_op(ppbb_pkg::OP_WRITE, 8'h66, 1'b0);
        add_op(ppbb_pkg::OP_READ,  8'h00, 1'b0);

        // Lowering the size below the fill count blocks writes until the buffer resets.
        set_buffer_size(ppbb_pkg::SIZE_W'(2));
        add_op(ppbb_pkg::OP_WRITE, 8'h77, 1'b0);
        add_op(ppbb_pkg::OP_READ,  8'h00, 1'b1);
        add_op(ppbb_pkg::OP_READ,  8'h00, 1'b0);
        add_op(ppbb_pkg::OP_WRITE, 8'h99, 1'b0);
        add_op(ppbb_pkg::OP_WRITE, 8'h44, 1'b0);
        add_op(ppbb_pkg::OP_WRITE, 8'h22, 1'b1);
        add_op(ppbb_pkg::OP_WRITE, 8'h11, 1'b0);
        add_op(ppbb_pkg::OP_READ,  8'h00, 1'b0);

        for (int p = 0; p < 12; p++) begin
            set_buffer_size(ppbb_pkg::SIZE_W'(sizes[p]));
            send_idle_pct  = send_pcts[p % 4];
            recv_stall_pct = recv_pcts[p % 4];
            add_traffic(163, sizes[p]);
        end

        wait_drained();
        recv_stall_pct = 0;
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("tb_ping_pong_byte_buffer_unit: clean");
        end else begin
            $display("tb_ping_pong_byte_buffer_unit: errors");
        end
        $finish;
    end

endmodule

// ===== ping_pong_byte_buffer_unit.f =====
hw/rtl/ppbb_pkg.sv
hw/rtl/ppbb_mem.sv
hw/rtl/ppbb_ctrl.sv
hw/rtl/ppbb_out.sv
hw/rtl/ping_pong_byte_buffer_unit.sv
tb/sv/tb_ping_pong_byte_buffer_unit.sv
